### design/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg: shared types and constants for the 1-Wire master
// Item and result structs, operation classes, status codes, register
// indexes and register reset values.
// ----------------------------------------------------------------------------
package owm_pkg;

  // Default width of the tick counter
  localparam int TICK_COUNTER_BITS_DEF = 10;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Command kinds as they arrive on the input channel
  localparam logic [2:0] KIND_TICK     = 3'd0;
  localparam logic [2:0] KIND_RESET    = 3'd1;
  localparam logic [2:0] KIND_WRITE    = 3'd2;
  localparam logic [2:0] KIND_RD_BYTE  = 3'd3;
  localparam logic [2:0] KIND_RD_SLOT  = 3'd4;

  // Status codes of a result
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_RESET_LOW    = 3'd0;
  localparam logic [2:0] REG_PRES_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_RECOVERY     = 3'd2;
  localparam logic [2:0] REG_ONE_LOW      = 3'd3;
  localparam logic [2:0] REG_ZERO_LOW     = 3'd4;
  localparam logic [2:0] REG_SLOT         = 3'd5;
  localparam logic [2:0] REG_READ_LOW     = 3'd6;
  localparam logic [2:0] REG_SAMPLE_DELAY = 3'd7;

  // Register reset values
  localparam logic [9:0] RST_RESET_LOW    = 10'd480;
  localparam logic [9:0] RST_PRES_TIMEOUT = 10'd999;
  localparam logic [9:0] RST_RECOVERY     = 10'd405;
  localparam logic [5:0] RST_ONE_LOW      = 6'd13;
  localparam logic [6:0] RST_ZERO_LOW     = 7'd60;
  localparam logic [6:0] RST_SLOT         = 7'd61;
  localparam logic [3:0] RST_READ_LOW     = 4'd1;
  localparam logic [5:0] RST_SAMPLE_DELAY = 6'd5;

  // Reflected CRC-8 polynomial
  localparam logic [7:0] CRC_POLY = 8'h8C;

  localparam int CFG_DATA_BITS = 10;

  // Operation class assigned by the front end
  typedef enum logic [2:0] {
    OP_NOP,
    OP_TICK,
    OP_RESET,
    OP_WRITE,
    OP_RD_BYTE,
    OP_RD_BIT
  } owm_op_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       line_level;
  } owm_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_data;
    logic [7:0] crc_value;
  } owm_out_t;

  // Classified item held in the queue
  typedef struct packed {
    owm_op_t    op;
    logic [7:0] data_byte;
    logic       line_level;
  } owm_item_t;

  typedef struct packed {
    logic [9:0] reset_low_ticks;
    logic [9:0] presence_timeout;
    logic [9:0] recovery_ticks;
    logic [5:0] one_low_ticks;
    logic [6:0] zero_low_ticks;
    logic [6:0] slot_ticks;
    logic [3:0] read_low_ticks;
    logic [5:0] sample_delay_ticks;
  } owm_cfg_t;

endpackage

### design/owm_front.sv
// ----------------------------------------------------------------------------
// owm_front: command intake
// Classifies each incoming item into an operation and holds it in a short
// queue until the sequencer takes it.
// ----------------------------------------------------------------------------
module owm_front
  import owm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  owm_in_t   cmd,
  output logic      q_valid,
  output owm_item_t q_item,
  input  logic      q_pop
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  owm_item_t       queue [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  owm_item_t       item;
  logic            push;
  logic            pop;

  // Map the raw kind code onto an operation class; unknown codes do nothing
  always_comb begin
    item.data_byte  = cmd.data_byte;
    item.line_level = cmd.line_level;
    case (cmd.kind)
      KIND_TICK:    item.op = OP_TICK;
      KIND_RESET:   item.op = OP_RESET;
      KIND_WRITE:   item.op = OP_WRITE;
      KIND_RD_BYTE: item.op = OP_RD_BYTE;
      KIND_RD_SLOT: item.op = OP_RD_BIT;
      default:      item.op = OP_NOP;
    endcase
  end

  assign cmd_ready = (count != CNTW'(QUEUE_DEPTH));
  assign push      = cmd_valid && cmd_ready;
  assign q_valid   = (count != '0);
  assign pop       = q_pop && q_valid;
  assign q_item    = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/owm_back.sv
// ----------------------------------------------------------------------------
// owm_back: bus sequencer
// Carries out one queued operation per cycle, unless res stalls, against the
// bus state machine, updates the CRC, holds the result in the output register.
// ----------------------------------------------------------------------------
module owm_back
  import owm_pkg::*;
#(
  parameter int TICK_COUNTER_BITS = TICK_COUNTER_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  owm_cfg_t  cfg,
  input  logic      q_valid,
  input  owm_item_t q_item,
  output logic      q_pop,
  output logic      res_valid,
  input  logic      res_ready,
  output owm_out_t  res
);

  localparam int TCB = TICK_COUNTER_BITS;
  localparam int CW  = (TCB > 11) ? TCB : 11;
  localparam logic [TCB-1:0] CNT_MAX   = '1;
  localparam logic [CW-1:0]  CNT_MAX_W = CW'(CNT_MAX);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_WAIT_HI1,
    PH_WAIT_LO,
    PH_WAIT_HI2,
    PH_RECOVER,
    PH_WRITE,
    PH_RD_BYTE,
    PH_RD_BIT
  } phase_t;

  phase_t         phase, phase_next;
  logic [TCB-1:0] tick_count, tick_count_next;
  logic [2:0]     bit_index, bit_index_next;
  logic [7:0]     shift_byte, shift_byte_next;
  logic [7:0]     crc_reg, crc_reg_next;

  logic [TCB-1:0] l_rst, l_pto, l_rec, l_one, l_zero, l_slot, l_rlow, l_sp, l_sum;
  logic [TCB-1:0] tick_inc;
  logic [TCB-1:0] low_time;
  logic           done;
  logic [1:0]     status;
  logic [7:0]     rdata;
  logic           want;
  logic           crc_fb;
  logic           drive;
  logic           take;

  // Clamp a configured count to the counter range
  function automatic logic [TCB-1:0] lim_f(input logic [CW-1:0] v);
    if (v > CNT_MAX_W) begin
      lim_f = CNT_MAX;
    end else begin
      lim_f = v[TCB-1:0];
    end
  endfunction

  always_comb begin
    l_rst  = lim_f(CW'(cfg.reset_low_ticks));
    l_pto  = lim_f(CW'(cfg.presence_timeout));
    l_rec  = lim_f(CW'(cfg.recovery_ticks));
    l_one  = lim_f(CW'(cfg.one_low_ticks));
    l_zero = lim_f(CW'(cfg.zero_low_ticks));
    l_slot = lim_f(CW'(cfg.slot_ticks));
    if (l_slot == '0) begin
      l_slot = TCB'(1);
    end
    l_rlow = lim_f(CW'(cfg.read_low_ticks));
    l_sum  = lim_f(CW'(cfg.read_low_ticks) + CW'(cfg.sample_delay_ticks));
    l_sp   = (l_sum > l_slot) ? l_slot : l_sum;
  end

  assign tick_inc = (tick_count == CNT_MAX) ? tick_count : tick_count + 1'b1;

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    crc_reg_next    = crc_reg;
    done            = 1'b0;
    status          = ST_OK;
    rdata           = '0;
    want            = (phase != PH_WAIT_LO);
    crc_fb          = q_item.line_level ^ crc_reg[0];

    case (q_item.op)
      OP_TICK: begin
        case (phase)
          PH_RST_LOW: begin
            tick_count_next = tick_inc;
            if (tick_inc >= l_rst) begin
              phase_next      = PH_WAIT_HI1;
              tick_count_next = '0;
            end
          end
          PH_WAIT_HI1, PH_WAIT_LO, PH_WAIT_HI2: begin
            if (q_item.line_level == want) begin
              tick_count_next = '0;
              if (phase == PH_WAIT_HI2) begin
                if (l_rec == '0) begin
                  phase_next = PH_IDLE;
                  done       = 1'b1;
                end else begin
                  phase_next = PH_RECOVER;
                end
              end else if (phase == PH_WAIT_HI1) begin
                phase_next = PH_WAIT_LO;
              end else begin
                phase_next = PH_WAIT_HI2;
              end
            end else if (tick_count >= l_pto) begin
              phase_next      = PH_IDLE;
              tick_count_next = '0;
              done            = 1'b1;
              status          = ST_TIMEOUT;
            end else begin
              tick_count_next = tick_inc;
            end
          end
          PH_RECOVER: begin
            tick_count_next = tick_inc;
            if (tick_inc >= l_rec) begin
              phase_next      = PH_IDLE;
              tick_count_next = '0;
              done            = 1'b1;
            end
          end
          PH_WRITE: begin
            tick_count_next = tick_inc;
            if (tick_inc >= l_slot) begin
              tick_count_next = '0;
              if (bit_index == 3'd7) begin
                phase_next     = PH_IDLE;
                bit_index_next = '0;
                done           = 1'b1;
              end else begin
                bit_index_next = bit_index + 1'b1;
              end
            end
          end
          PH_RD_BYTE, PH_RD_BIT: begin
            tick_count_next = tick_inc;
            if (tick_inc == l_sp) begin
              shift_byte_next = shift_byte | ({7'd0, q_item.line_level} << bit_index);
              crc_reg_next    = (crc_reg >> 1) ^ (crc_fb ? CRC_POLY : 8'h00);
            end
            if (tick_inc >= l_slot) begin
              tick_count_next = '0;
              if (phase == PH_RD_BIT || bit_index == 3'd7) begin
                phase_next     = PH_IDLE;
                bit_index_next = '0;
                done           = 1'b1;
                rdata          = shift_byte_next;
              end else begin
                bit_index_next = bit_index + 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      OP_RESET, OP_WRITE, OP_RD_BYTE, OP_RD_BIT: begin
        if (phase != PH_IDLE) begin
          status = ST_REJECT;
        end else begin
          tick_count_next = '0;
          bit_index_next  = '0;
          case (q_item.op)
            OP_RESET: begin
              crc_reg_next = '0;
              phase_next   = PH_RST_LOW;
            end
            OP_WRITE: begin
              shift_byte_next = q_item.data_byte;
              phase_next      = PH_WRITE;
            end
            OP_RD_BYTE: begin
              shift_byte_next = '0;
              phase_next      = PH_RD_BYTE;
            end
            default: begin
              shift_byte_next = '0;
              phase_next      = PH_RD_BIT;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // Bus drive as it stands after this item
  always_comb begin
    low_time = shift_byte_next[bit_index_next] ? l_one : l_zero;
    case (phase_next)
      PH_RST_LOW:            drive = 1'b1;
      PH_WRITE:              drive = (tick_count_next < low_time);
      PH_RD_BYTE, PH_RD_BIT: drive = (tick_count_next < l_rlow);
      default:               drive = 1'b0;
    endcase
  end

  assign take  = q_valid && (!res_valid || res_ready);
  assign q_pop = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      bit_index  <= '0;
      shift_byte <= '0;
      crc_reg    <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (take) begin
        phase         <= phase_next;
        tick_count    <= tick_count_next;
        bit_index     <= bit_index_next;
        shift_byte    <= shift_byte_next;
        crc_reg       <= crc_reg_next;
        res_valid     <= 1'b1;
        res.drive_low <= drive;
        res.busy_res  <= (phase_next != PH_IDLE);
        res.done_res  <= done;
        res.status    <= status;
        res.read_data <= rdata;
        res.crc_value <= crc_reg_next;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

### design/one_wire_master_with_crc8.sv
// ----------------------------------------------------------------------------
// one_wire_master_with_crc8: item-driven 1-Wire bus master with CRC-8
// Top level: configuration registers, command intake and bus sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Feed items on cmd (valid/ready). A tick item stands for one microsecond
//   and carries the sampled bus level; command items start a reset/presence
//   sequence, a byte write, a byte read or a single read slot. Each item
//   gives exactly one result on res (valid/ready): bus drive, busy, done,
//   status, read data and the running CRC-8.
//   An item passes through the queue and its result is held in the result
//   register. Throughput: one item per cycle while res is not stalled, set
//   by the sequencer update (one counter increment and compare per item).
//   A two-entry queue parts intake from the sequencer and the result register
//   parts the sequencer from the receiver: while res is stalled, intake keeps
//   taking items until the queue fills, then drops cmd_ready.
//   Reset (rst, synchronous) empties the queue, drops res_valid, returns the
//   sequencer to idle with zeroed counters and CRC, and loads the register
//   reset values. Write registers through cfg_we/cfg_index/cfg_data only
//   while the block is idle; a write takes effect at once.
// ----------------------------------------------------------------------------
module one_wire_master_with_crc8
  import owm_pkg::*;
#(
  parameter int TICK_COUNTER_BITS = TICK_COUNTER_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_ready,
  input  owm_in_t                  cmd,
  output logic                     res_valid,
  input  logic                     res_ready,
  output owm_out_t                 res,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  owm_cfg_t  cfg;
  logic      q_valid;
  owm_item_t q_item;
  logic      q_pop;

  // Configuration registers: store the low bits of the write data
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks    <= RST_RESET_LOW;
      cfg.presence_timeout   <= RST_PRES_TIMEOUT;
      cfg.recovery_ticks     <= RST_RECOVERY;
      cfg.one_low_ticks      <= RST_ONE_LOW;
      cfg.zero_low_ticks     <= RST_ZERO_LOW;
      cfg.slot_ticks         <= RST_SLOT;
      cfg.read_low_ticks     <= RST_READ_LOW;
      cfg.sample_delay_ticks <= RST_SAMPLE_DELAY;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESET_LOW:    cfg.reset_low_ticks    <= cfg_data[9:0];
        REG_PRES_TIMEOUT: cfg.presence_timeout   <= cfg_data[9:0];
        REG_RECOVERY:     cfg.recovery_ticks     <= cfg_data[9:0];
        REG_ONE_LOW:      cfg.one_low_ticks      <= cfg_data[5:0];
        REG_ZERO_LOW:     cfg.zero_low_ticks     <= cfg_data[6:0];
        REG_SLOT:         cfg.slot_ticks         <= cfg_data[6:0];
        REG_READ_LOW:     cfg.read_low_ticks     <= cfg_data[3:0];
        REG_SAMPLE_DELAY: cfg.sample_delay_ticks <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  // Intake: classify and queue each transfer
  owm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // Sequencer: advance the bus state and register the result
  owm_back #(
    .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

`ifndef NO_ASSERTIONS
  // A finished operation leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.done_res |-> !res.busy_res)
    else $error("done result reports busy");

  // A rejected command only happens while busy and never finishes anything
  a_reject: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_REJECT |-> res.busy_res && !res.done_res)
    else $error("rejected command with bad busy/done");

  // A presence timeout ends the sequence with the bus released
  a_timeout: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_TIMEOUT |-> res.done_res && !res.drive_low)
    else $error("timeout without done or with bus driven");

  // Read data shows up only on the finishing result
  a_rdata: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.read_data != 8'd0 |-> res.done_res)
    else $error("read data outside a done result");
`endif

endmodule
